FILE: hw/rtl/bmp_pkg.sv
// Shared types and constants for the BMP 24-bit to RGB565 pixel writer.
// Used by every module in hw/rtl; no dependencies.
package bmp_pkg;

    localparam int MAX_DIM    = 64;
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int HDR_LEN    = 54;
    localparam int OFS_WIDTH  = 18;
    localparam int OFS_HEIGHT = 22;
    localparam int OFS_DEPTH  = 28;
    localparam int DEPTH_24   = 24;
    localparam int HCNT_W     = 6;
    localparam int ORG_W      = 6;
    localparam int COORD_W    = 7;
    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [0:0] REG_ORIGIN_X = 1'b0;
    localparam logic [0:0] REG_ORIGIN_Y = 1'b1;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_PIXELS = 2'd1,
        MODE_IDLE   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_BAD_DEPTH = 2'd1,
        KIND_TOO_BIG   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic             last;
    } t_cmd;

endpackage

FILE: hw/rtl/bmp24_to_rgb565_pixel_writer.sv
// A result word passes through the command queue and the back end's output register before it reaches the result ports.
// Throughput: one file byte per cycle while full is low; a pixel write every third pixel byte.
// The parser never stalls on its own; full rises only when the 4-deep command queue fills.
// Reset (synchronous, active low): header parsing from offset 0, queue and output emptied,
// origin registers cleared to 0.
// Top level: config registers, parser front end, command queue, output back end.
module bmp24_to_rgb565_pixel_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_file_start,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [1:0]                  o_kind,
    output logic [bmp_pkg::COORD_W-1:0] o_pix_x,
    output logic [bmp_pkg::COORD_W-1:0] o_pix_y,
    output logic [bmp_pkg::COLOR_W-1:0] o_color,
    output logic                        o_last_pixel,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [bmp_pkg::DATA_W-1:0]  pwdata,
    output logic [bmp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [bmp_pkg::ORG_W-1:0] r_origin_x, r_origin_y;
    logic                      accept;
    logic                      cmd_valid;
    bmp_pkg::t_cmd             cmd;
    bmp_pkg::t_cmd             head;
    logic                      head_valid;
    logic                      take;
    logic [0:0]                reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                bmp_pkg::REG_ORIGIN_X: r_origin_x <= pwdata[bmp_pkg::ORG_W-1:0];
                bmp_pkg::REG_ORIGIN_Y: r_origin_y <= pwdata[bmp_pkg::ORG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bmp_pkg::REG_ORIGIN_X: prdata = bmp_pkg::DATA_W'(r_origin_x);
            bmp_pkg::REG_ORIGIN_Y: prdata = bmp_pkg::DATA_W'(r_origin_y);
            default:               prdata = '0;
        endcase
    end

    assign accept = i_push && !o_full;

    bmp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    bmp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .i_pop   (take),
        .o_cmd   (head),
        .o_valid (head_valid),
        .o_full  (o_full)
    );

    bmp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_take       (take),
        .i_origin_x   (r_origin_x),
        .i_origin_y   (r_origin_y),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_kind       (o_kind),
        .o_pix_x      (o_pix_x),
        .o_pix_y      (o_pix_y),
        .o_color      (o_color),
        .o_last_pixel (o_last_pixel)
    );

endmodule

FILE: hw/rtl/bmp_front.sv
// Front end: header capture, image classification and pixel byte assembly.
// Depends on bmp_pkg; emits one command word per error or completed pixel.
module bmp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_file_start,
    output logic            o_cmd_valid,
    output bmp_pkg::t_cmd   o_cmd
);

    bmp_pkg::t_mode                r_mode, n_mode;
    logic [bmp_pkg::HCNT_W-1:0]    r_hcnt, n_hcnt;
    logic [31:0]                   r_width, n_width;
    logic [31:0]                   r_height, n_height;
    logic [15:0]                   r_depth, n_depth;
    logic [bmp_pkg::CNT_W-1:0]     r_col, n_col;
    logic [bmp_pkg::CNT_W-1:0]     r_row, n_row;
    logic [1:0]                    r_phase, n_phase;
    logic [15:0]                   r_hold, n_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bmp_pkg::MODE_HEADER;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_phase  <= '0;
        end else begin
            r_hcnt   <= n_hcnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_col    <= n_col;
            r_row    <= n_row;
            r_phase  <= n_phase;
        end
        r_hold <= n_hold;
    end

    always_comb begin
        logic [1:0]                sel;
        logic [bmp_pkg::CNT_W:0]   col_inc;
        logic                      row_end;
        logic                      too_big;
        logic                      not_pos;

        n_mode      = r_mode;
        n_hcnt      = r_hcnt;
        n_width     = r_width;
        n_height    = r_height;
        n_depth     = r_depth;
        n_col       = r_col;
        n_row       = r_row;
        n_phase     = r_phase;
        n_hold      = r_hold;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        sel         = '0;
        col_inc     = '0;
        row_end     = 1'b0;
        too_big     = 1'b0;
        not_pos     = 1'b0;

        if (i_valid) begin
            if (i_file_start) begin
                n_mode   = bmp_pkg::MODE_HEADER;
                n_hcnt   = '0;
                n_width  = '0;
                n_height = '0;
                n_depth  = '0;
                n_col    = '0;
                n_row    = '0;
                n_phase  = '0;
                n_hold   = '0;
            end

            case (n_mode)
                bmp_pkg::MODE_HEADER: begin
                    if (n_hcnt >= bmp_pkg::HCNT_W'(bmp_pkg::OFS_WIDTH) &&
                        n_hcnt <  bmp_pkg::HCNT_W'(bmp_pkg::OFS_WIDTH + 4)) begin
                        sel = 2'(n_hcnt - bmp_pkg::HCNT_W'(bmp_pkg::OFS_WIDTH));
                        n_width[{sel, 3'b000} +: 8] = i_data_byte;
                    end else if (n_hcnt >= bmp_pkg::HCNT_W'(bmp_pkg::OFS_HEIGHT) &&
                                 n_hcnt <  bmp_pkg::HCNT_W'(bmp_pkg::OFS_HEIGHT + 4)) begin
                        sel = 2'(n_hcnt - bmp_pkg::HCNT_W'(bmp_pkg::OFS_HEIGHT));
                        n_height[{sel, 3'b000} +: 8] = i_data_byte;
                    end else if (n_hcnt >= bmp_pkg::HCNT_W'(bmp_pkg::OFS_DEPTH) &&
                                 n_hcnt <  bmp_pkg::HCNT_W'(bmp_pkg::OFS_DEPTH + 2)) begin
                        sel = 2'(n_hcnt - bmp_pkg::HCNT_W'(bmp_pkg::OFS_DEPTH));
                        n_depth[{sel[0], 3'b000} +: 8] = i_data_byte;
                    end

                    if (n_hcnt == bmp_pkg::HCNT_W'(bmp_pkg::HDR_LEN - 1)) begin
                        n_hcnt  = '0;
                        n_mode  = bmp_pkg::MODE_IDLE;
                        too_big = (!n_width[31] && n_width > 32'(bmp_pkg::MAX_DIM)) ||
                                  (!n_height[31] && n_height > 32'(bmp_pkg::MAX_DIM));
                        not_pos = n_width == '0 || n_width[31] ||
                                  n_height == '0 || n_height[31];
                        if (n_depth != 16'(bmp_pkg::DEPTH_24)) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = bmp_pkg::KIND_BAD_DEPTH;
                        end else if (too_big) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = bmp_pkg::KIND_TOO_BIG;
                        end else if (!not_pos) begin
                            n_mode  = bmp_pkg::MODE_PIXELS;
                            n_row   = bmp_pkg::CNT_W'(n_height - 32'd1);
                            n_col   = '0;
                            n_phase = '0;
                            n_hold  = '0;
                        end
                    end else begin
                        n_hcnt = n_hcnt + 1'b1;
                    end
                end
                bmp_pkg::MODE_PIXELS: begin
                    case (n_phase)
                        2'd0: begin
                            n_hold  = {i_data_byte, 8'h00};
                            n_phase = 2'd1;
                        end
                        2'd1: begin
                            n_hold[7:0] = i_data_byte;
                            n_phase     = 2'd2;
                        end
                        default: begin
                            col_inc = {1'b0, n_col} + 1'b1;
                            row_end = col_inc >= {1'b0, n_width[bmp_pkg::CNT_W-1:0]};
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = bmp_pkg::KIND_PIXEL;
                            o_cmd.col   = n_col;
                            o_cmd.row   = n_row;
                            o_cmd.blue  = n_hold[15:8];
                            o_cmd.green = n_hold[7:0];
                            o_cmd.red   = i_data_byte;
                            o_cmd.last  = row_end && n_row == '0;
                            n_phase     = 2'd0;
                            if (row_end) begin
                                n_col = '0;
                                if (n_row == '0) begin
                                    n_mode = bmp_pkg::MODE_IDLE;
                                end else begin
                                    n_row = n_row - 1'b1;
                                end
                            end else begin
                                n_col = col_inc[bmp_pkg::CNT_W-1:0];
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/bmp_cmdq.sv
// Short command queue between the parser front end and the output back end.
// Depends on bmp_pkg for the command word type and depth.
module bmp_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bmp_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output bmp_pkg::t_cmd   o_cmd,
    output logic            o_valid,
    output logic            o_full
);

    bmp_pkg::t_cmd               r_mem [bmp_pkg::QDEPTH];
    logic [bmp_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [bmp_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = r_count == bmp_pkg::QCNT_W'(bmp_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bmp_pkg::QCNT_W'(bmp_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == bmp_pkg::QCNT_W'($past(r_count) + 1'b1))
        else $error("queue count not advanced on push");

endmodule

FILE: hw/rtl/bmp_back.sv
// Back end: packs color to 565, adds the origin and holds the result word.
// Depends on bmp_pkg; drains the command queue one word per cycle while the output is empty or popped.
module bmp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmp_pkg::t_cmd               i_head,
    input  logic                        i_head_valid,
    output logic                        o_take,
    input  logic [bmp_pkg::ORG_W-1:0]   i_origin_x,
    input  logic [bmp_pkg::ORG_W-1:0]   i_origin_y,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [1:0]                  o_kind,
    output logic [bmp_pkg::COORD_W-1:0] o_pix_x,
    output logic [bmp_pkg::COORD_W-1:0] o_pix_y,
    output logic [bmp_pkg::COLOR_W-1:0] o_color,
    output logic                        o_last_pixel
);

    logic                          r_valid;
    logic [1:0]                    r_kind;
    logic [bmp_pkg::COORD_W-1:0]   r_x, n_x;
    logic [bmp_pkg::COORD_W-1:0]   r_y, n_y;
    logic [bmp_pkg::COLOR_W-1:0]   r_color, n_color;
    logic                          r_last, n_last;

    assign o_take = i_head_valid && (!r_valid || i_pop);

    always_comb begin
        if (i_head.kind == bmp_pkg::KIND_PIXEL) begin
            n_x     = bmp_pkg::COORD_W'(i_origin_x) + bmp_pkg::COORD_W'(i_head.col);
            n_y     = bmp_pkg::COORD_W'(i_origin_y) + bmp_pkg::COORD_W'(i_head.row);
            n_color = {i_head.blue[7:3], i_head.green[7:2], i_head.red[7:3]};
            n_last  = i_head.last;
        end else begin
            n_x     = '0;
            n_y     = '0;
            n_color = '0;
            n_last  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind  <= i_head.kind;
            r_x     <= n_x;
            r_y     <= n_y;
            r_color <= n_color;
            r_last  <= n_last;
        end
    end

    assign o_empty      = !r_valid;
    assign o_kind       = r_kind;
    assign o_pix_x      = r_x;
    assign o_pix_y      = r_y;
    assign o_color      = r_color;
    assign o_last_pixel = r_last;

endmodule

FILE: test/tb_bmp24_to_rgb565_pixel_writer.sv
// Testbench for bmp24_to_rgb565_pixel_writer: streams BMP files through the byte queue,
// predicts every pixel and error word, and checks each popped word in order.
// Depends on bmp_pkg and the block's RTL only.
`timescale 1ns / 100ps

typedef struct packed {
    bmp_pkg::t_kind              kind;
    logic [bmp_pkg::COORD_W-1:0] x;
    logic [bmp_pkg::COORD_W-1:0] y;
    logic [bmp_pkg::COLOR_W-1:0] color;
    logic                        last;
} t_pixel_word;

class t_pixel_tracker;
    logic [bmp_pkg::ORG_W-1:0]   org_x;
    logic [bmp_pkg::ORG_W-1:0]   org_y;
    int                          hdr_ofs;
    logic [31:0]                 img_w;
    logic [31:0]                 img_h;
    logic [15:0]                 img_depth;
    logic [bmp_pkg::COORD_W-1:0] col;
    logic [bmp_pkg::COORD_W-1:0] row;
    int                          byte_sel;
    logic [7:0]                  held_blue;
    logic [7:0]                  held_green;
    bmp_pkg::t_mode              mode;
    t_pixel_word                 expected_writes[$];
    int                          mismatches;
    int                          pixels_due;

    function new();
        org_x      = '0;
        org_y      = '0;
        mismatches = 0;
        pixels_due = 0;
        clear_image();
    endfunction

    function void clear_image();
        mode       = bmp_pkg::MODE_HEADER;
        hdr_ofs    = 0;
        img_w      = '0;
        img_h      = '0;
        img_depth  = '0;
        col        = '0;
        row        = '0;
        byte_sel   = 0;
        held_blue  = '0;
        held_green = '0;
    endfunction

    function bit dim_over(logic [31:0] v);
        return !v[31] && v > 32'(bmp_pkg::MAX_DIM);
    endfunction

    function void queue_word(bmp_pkg::t_kind k, logic [bmp_pkg::COORD_W-1:0] x,
                             logic [bmp_pkg::COORD_W-1:0] y,
                             logic [bmp_pkg::COLOR_W-1:0] color, logic last);
        t_pixel_word w;
        w.kind  = k;
        w.x     = x;
        w.y     = y;
        w.color = color;
        w.last  = last;
        expected_writes.push_back(w);
    endfunction

    function void take_byte(logic [7:0] d, logic s);
        logic row_end;
        if (s)
            clear_image();
        case (mode)
            bmp_pkg::MODE_HEADER: begin
                if (hdr_ofs >= bmp_pkg::OFS_WIDTH && hdr_ofs < bmp_pkg::OFS_WIDTH + 4)
                    img_w[8*(hdr_ofs-bmp_pkg::OFS_WIDTH) +: 8] = d;
                else if (hdr_ofs >= bmp_pkg::OFS_HEIGHT && hdr_ofs < bmp_pkg::OFS_HEIGHT + 4)
                    img_h[8*(hdr_ofs-bmp_pkg::OFS_HEIGHT) +: 8] = d;
                else if (hdr_ofs >= bmp_pkg::OFS_DEPTH && hdr_ofs < bmp_pkg::OFS_DEPTH + 2)
                    img_depth[8*(hdr_ofs-bmp_pkg::OFS_DEPTH) +: 8] = d;
                if (hdr_ofs < bmp_pkg::HDR_LEN - 1) begin
                    hdr_ofs++;
                end else begin
                    hdr_ofs = 0;
                    mode    = bmp_pkg::MODE_IDLE;
                    if (img_depth != 16'(bmp_pkg::DEPTH_24)) begin
                        queue_word(bmp_pkg::KIND_BAD_DEPTH, '0, '0, '0, 1'b0);
                    end else if (dim_over(img_w) || dim_over(img_h)) begin
                        queue_word(bmp_pkg::KIND_TOO_BIG, '0, '0, '0, 1'b0);
                    end else if (img_w != 0 && !img_w[31] && img_h != 0 && !img_h[31]) begin
                        mode     = bmp_pkg::MODE_PIXELS;
                        row      = bmp_pkg::COORD_W'(img_h - 1);
                        col      = '0;
                        byte_sel = 0;
                    end
                end
            end
            bmp_pkg::MODE_PIXELS: begin
                if (byte_sel == 0) begin
                    held_blue = d;
                    byte_sel  = 1;
                end else if (byte_sel == 1) begin
                    held_green = d;
                    byte_sel   = 2;
                end else begin
                    row_end = (32'(col) + 1 >= img_w);
                    queue_word(bmp_pkg::KIND_PIXEL, bmp_pkg::COORD_W'(org_x) + col,
                               bmp_pkg::COORD_W'(org_y) + row,
                               {held_blue[7:3], held_green[7:2], d[7:3]},
                               row_end && row == 0);
                    pixels_due++;
                    byte_sel = 0;
                    if (row_end) begin
                        col = '0;
                        if (row == 0)
                            mode = bmp_pkg::MODE_IDLE;
                        else
                            row--;
                    end else begin
                        col++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void report(string what, t_pixel_word want, t_pixel_word got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected kind=%0d x=%0d y=%0d color=%h last=%0b",
                     $time, what, want.kind, want.x, want.y, want.color, want.last,
                     "  got kind=%0d x=%0d y=%0d color=%h last=%0b",
                     got.kind, got.x, got.y, got.color, got.last);
    endfunction

    function void check_word(t_pixel_word got);
        t_pixel_word want;
        if (expected_writes.size() == 0) begin
            report("unexpected word", '0, got);
            return;
        end
        want = expected_writes.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.color !== want.color || got.last !== want.last)
            report("word mismatch", want, got);
    endfunction

    function void flush_leftovers();
        while (expected_writes.size() != 0)
            report("missing word", expected_writes.pop_front(), '0);
    endfunction
endclass

module tb_bmp24_to_rgb565_pixel_writer;

    localparam logic [bmp_pkg::ADDR_W-1:0] ADDR_ORIGIN_X =
        bmp_pkg::ADDR_W'({bmp_pkg::REG_ORIGIN_X, 2'b00});
    localparam logic [bmp_pkg::ADDR_W-1:0] ADDR_ORIGIN_Y =
        bmp_pkg::ADDR_W'({bmp_pkg::REG_ORIGIN_Y, 2'b00});
    localparam logic [15:0] DEPTH_OK = 16'(bmp_pkg::DEPTH_24);

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_push       = 1'b0;
    logic [7:0]                  i_data_byte  = '0;
    logic                        i_file_start = 1'b0;
    logic                        i_pop        = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [bmp_pkg::ADDR_W-1:0]  paddr        = '0;
    logic [bmp_pkg::DATA_W-1:0]  pwdata       = '0;
    logic                        o_full;
    logic                        o_empty;
    logic [1:0]                  o_kind;
    logic [bmp_pkg::COORD_W-1:0] o_pix_x;
    logic [bmp_pkg::COORD_W-1:0] o_pix_y;
    logic [bmp_pkg::COLOR_W-1:0] o_color;
    logic                        o_last_pixel;
    logic [bmp_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;

    t_pixel_tracker tracker = new();

    bmp24_to_rgb565_pixel_writer dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty)
            tracker.check_word(t_pixel_word'({o_kind, o_pix_x, o_pix_y, o_color, o_last_pixel}));
        i_pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    task automatic send_byte(logic [7:0] d, logic s);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push       <= 1'b1;
        i_data_byte  <= d;
        i_file_start <= s;
        do @(posedge i_clk); while (o_full);
        tracker.take_byte(d, s);
        bytes_sent++;
    endtask

    task automatic send_file(logic [31:0] w, logic [31:0] h, logic [15:0] dep, int hdr_bytes,
                             int pix_bytes, int tail_bytes, bit marked, bit extremes);
        logic [7:0] hdr [bmp_pkg::HDR_LEN];
        for (int i = 0; i < bmp_pkg::HDR_LEN; i++)
            hdr[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) begin
            hdr[bmp_pkg::OFS_WIDTH+i]  = w[8*i +: 8];
            hdr[bmp_pkg::OFS_HEIGHT+i] = h[8*i +: 8];
        end
        hdr[bmp_pkg::OFS_DEPTH]   = dep[7:0];
        hdr[bmp_pkg::OFS_DEPTH+1] = dep[15:8];
        for (int i = 0; i < hdr_bytes; i++)
            send_byte(hdr[i], marked && i == 0);
        for (int i = 0; i < pix_bytes; i++)
            send_byte(extremes ? {8{i[0]}} : 8'($urandom), 1'b0);
        for (int i = 0; i < tail_bytes; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_random_file();
        int          r;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] dep;
        int          hb;
        int          pb;
        int          tail;
        r    = $urandom_range(99, 0);
        w    = $urandom_range(4, 1);
        h    = $urandom_range(4, 1);
        dep  = DEPTH_OK;
        hb   = bmp_pkg::HDR_LEN;
        tail = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(6, 1);
        if (r < 6) begin
            w = $urandom_range(bmp_pkg::MAX_DIM, 5);
            h = $urandom_range(2, 1);
        end
        pb = 3 * int'(w) * int'(h);
        if (r >= 72 && r < 80) begin
            dep = 16'($urandom);
            if (dep == DEPTH_OK)
                dep = 16'hFFFF;
            w  = $urandom;
            h  = $urandom;
            pb = 0;
        end else if (r >= 80 && r < 88) begin
            if ($urandom_range(1, 0))
                w = $urandom_range(2000, bmp_pkg::MAX_DIM + 1);
            else
                h = $urandom_range(2000, bmp_pkg::MAX_DIM + 1);
            if ($urandom_range(3, 0) == 0)
                w = $urandom | 32'h4000_0000;
            pb = 0;
        end else if (r >= 88 && r < 94) begin
            if ($urandom_range(1, 0))
                w = $urandom_range(1, 0) ? 32'h0 : ($urandom | 32'h8000_0000);
            else
                h = $urandom_range(1, 0) ? 32'h0 : ($urandom | 32'h8000_0000);
            pb = 0;
        end else if (r >= 94) begin
            tail = 0;
            if ($urandom_range(1, 0)) begin
                hb = $urandom_range(bmp_pkg::HDR_LEN - 1, 1);
                pb = 0;
            end else begin
                pb = $urandom_range(pb - 1, 0);
            end
        end
        send_file(w, h, dep, hb, pb, tail, 1'b1, 1'b0);
    endtask

    task automatic write_reg(logic [bmp_pkg::ADDR_W-1:0] addr,
                             logic [bmp_pkg::ORG_W-1:0] value);
        logic [bmp_pkg::DATA_W-1:0] word;
        word                     = $urandom;
        word[bmp_pkg::ORG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_ORIGIN_X)
            tracker.org_x = value;
        else
            tracker.org_y = value;
        @(posedge i_clk);
    endtask

    task automatic set_origin(logic [bmp_pkg::ORG_W-1:0] x, logic [bmp_pkg::ORG_W-1:0] y);
        write_reg(ADDR_ORIGIN_X, x);
        write_reg(ADDR_ORIGIN_Y, y);
    endtask

    task automatic settle();
        i_push <= 1'b0;
        while (tracker.expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        int first_byte;
        int first_pix;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first_byte     = bytes_sent;
        first_pix      = tracker.pixels_due;
        while (bytes_sent - first_byte < 60 || tracker.pixels_due - first_pix < 4)
            send_random_file();
        settle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header bytes arriving before any file start
        send_file(2, 1, DEPTH_OK, bmp_pkg::HDR_LEN, 6, 0, 1'b0, 1'b1);
        // bad depth and bad size together, then ignored bytes
        send_file(100, 200, 16, bmp_pkg::HDR_LEN, 0, 2, 1'b1, 1'b0);
        // width too big only through its upper bytes
        send_file(32'h0001_0001, 1, DEPTH_OK, bmp_pkg::HDR_LEN, 0, 0, 1'b1, 1'b0);
        // zero width and negative height end silently
        send_file(0, 32'hFFFF_FFFF, DEPTH_OK, bmp_pkg::HDR_LEN, 0, 1, 1'b1, 1'b0);
        settle();

        set_origin(6'd63, 6'd63);
        // new file cuts a header mid-way, then the largest image mid-pixel
        send_file(2, 2, DEPTH_OK, 20, 0, 0, 1'b1, 1'b0);
        send_file(bmp_pkg::MAX_DIM, bmp_pkg::MAX_DIM, DEPTH_OK, bmp_pkg::HDR_LEN, 10, 0,
                  1'b1, 1'b1);
        send_file(2, 2, DEPTH_OK, bmp_pkg::HDR_LEN, 12, 0, 1'b1, 1'b1);
        settle();

        set_origin(6'($urandom), 6'($urandom));
        run_phase(55, 0);
        set_origin(6'd63, 6'd0);
        run_phase(0, 55);
        set_origin(6'($urandom), 6'($urandom));
        run_phase(38, 38);

        tracker.flush_leftovers();
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_front.sv
hw/rtl/bmp_cmdq.sv
hw/rtl/bmp_back.sv
hw/rtl/bmp24_to_rgb565_pixel_writer.sv
test/tb_bmp24_to_rgb565_pixel_writer.sv
